// File: hw/rtl/bsfb_pkg.sv
// shared types and constants for the bitmap stream to framebuffer blitter
package bsfb_pkg;

    // header layout
    localparam logic [8:0] HDR_OFFSET_BYTE = 9'h00E;
    localparam logic [8:0] HDR_WIDTH_LO    = 9'h012;
    localparam logic [8:0] HDR_WIDTH_HI    = 9'h013;
    localparam logic [8:0] HDR_HEIGHT_LO   = 9'h016;
    localparam logic [8:0] HDR_HEIGHT_HI   = 9'h017;
    localparam logic [8:0] HDR_MIN_DATA    = 9'h018;

    // register reset values
    localparam logic [31:0] FRAME_BASE_RESET = 32'hD000_0000;
    localparam logic [15:0] ROW_PITCH_RESET  = 16'h1000;

    localparam int CFG_DATA_W = 32;

    // pixel queue between the parser and the address unit
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef enum logic [0:0] {
        REG_FRAME_BASE = 1'b0,
        REG_ROW_PITCH  = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_BYTE0 = 2'd0,
        PH_BYTE1 = 2'd1,
        PH_BYTE2 = 2'd2
    } phase_t;

    typedef struct packed {
        logic                  enable;
        reg_index_t            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    // one pixel as handed from the parser to the address unit
    typedef struct packed {
        logic [16:0] column;
        logic [16:0] row;
        logic [7:0]  byte_zero;
        logic [7:0]  byte_one;
        logic [7:0]  byte_two;
        logic        last_pixel;
    } pixel_token_t;

endpackage

// File: hw/rtl/bsfb_channels.sv
// stream interfaces for the file bytes and the pixel writes
interface bsfb_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] origin_x;
    logic [15:0] origin_y;

    modport source (output valid, output data_byte, output first_byte,
                    output origin_x, output origin_y, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input origin_x, input origin_y, output ready);
endinterface

interface bsfb_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] write_address;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic        last_pixel;

    modport source (output valid, output write_address, output byte_zero,
                    output byte_one, output byte_two, output last_pixel, input ready);
    modport sink   (input valid, input write_address, input byte_zero,
                    input byte_one, input byte_two, input last_pixel, output ready);
endinterface

// File: hw/rtl/bsfb_front.sv
// header parser and pixel assembler
module bsfb_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    bsfb_byte_if.sink             stream,
    input  logic                  queue_full,
    output logic                  push,
    output bsfb_pkg::pixel_token_t token
);

    logic [8:0]       hdr_pos_reg, hdr_pos_next;
    logic [8:0]       data_offset_reg, data_offset_next;
    logic [15:0]      width_reg, width_next;
    logic [15:0]      height_reg, height_next;
    logic [15:0]      col_reg, col_next;
    logic [15:0]      row_reg, row_next;
    bsfb_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [15:0]      start_col_reg, start_col_next;
    logic [15:0]      start_row_reg, start_row_next;
    logic             done_reg, done_next;

    logic             accept;
    logic [8:0]       offset_sum;
    logic [15:0]      rows_left;

    assign stream.ready = !queue_full;
    assign accept       = stream.valid && stream.ready;
    assign offset_sum   = bsfb_pkg::HDR_OFFSET_BYTE + {1'b0, stream.data_byte};

    always_comb
    begin
        hdr_pos_next     = hdr_pos_reg;
        data_offset_next = data_offset_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        phase_next       = phase_reg;
        held0_next       = held0_reg;
        held1_next       = held1_reg;
        start_col_next   = start_col_reg;
        start_row_next   = start_row_reg;
        done_next        = done_reg;
        push             = 1'b0;
        rows_left        = '0;
        token            = '0;

        if (accept)
        begin
            // restart drops whatever image was in progress
            if (stream.first_byte)
            begin
                hdr_pos_next     = '0;
                data_offset_next = '0;
                width_next       = '0;
                height_next      = '0;
                col_next         = '0;
                row_next         = '0;
                phase_next       = bsfb_pkg::PH_BYTE0;
                held0_next       = '0;
                held1_next       = '0;
                start_col_next   = stream.origin_x;
                start_row_next   = stream.origin_y;
                done_next        = 1'b0;
            end

            if (!done_next)
            begin
                if (hdr_pos_next < bsfb_pkg::HDR_MIN_DATA || hdr_pos_next < data_offset_next)
                begin
                    case (hdr_pos_next)
                        bsfb_pkg::HDR_OFFSET_BYTE:
                            data_offset_next = (offset_sum < bsfb_pkg::HDR_MIN_DATA) ?
                                               bsfb_pkg::HDR_MIN_DATA : offset_sum;
                        bsfb_pkg::HDR_WIDTH_LO:  width_next[7:0]   = stream.data_byte;
                        bsfb_pkg::HDR_WIDTH_HI:  width_next[15:8]  = stream.data_byte;
                        bsfb_pkg::HDR_HEIGHT_LO: height_next[7:0]  = stream.data_byte;
                        bsfb_pkg::HDR_HEIGHT_HI: height_next[15:8] = stream.data_byte;
                        default: ;
                    endcase
                    hdr_pos_next = hdr_pos_next + 9'd1;
                end
                else if (width_next == '0 || height_next == '0)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    case (phase_next)
                        bsfb_pkg::PH_BYTE0:
                        begin
                            held0_next = stream.data_byte;
                            phase_next = bsfb_pkg::PH_BYTE1;
                        end
                        bsfb_pkg::PH_BYTE1:
                        begin
                            held1_next = stream.data_byte;
                            phase_next = bsfb_pkg::PH_BYTE2;
                        end
                        default:
                        begin
                            // file rows run bottom-up, screen rows top-down
                            rows_left        = height_next - 16'd1 - row_next;
                            token.column     = {1'b0, start_col_next} + {1'b0, col_next};
                            token.row        = {1'b0, start_row_next} + {1'b0, rows_left};
                            token.byte_zero  = held0_next;
                            token.byte_one   = held1_next;
                            token.byte_two   = stream.data_byte;
                            phase_next       = bsfb_pkg::PH_BYTE0;
                            col_next         = col_next + 16'd1;
                            if (col_next >= width_next)
                            begin
                                col_next = '0;
                                row_next = row_next + 16'd1;
                            end
                            token.last_pixel = (row_next >= height_next);
                            if (token.last_pixel)
                            begin
                                done_next = 1'b1;
                            end
                            push = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg     <= '0;
            data_offset_reg <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            phase_reg       <= bsfb_pkg::PH_BYTE0;
            held0_reg       <= '0;
            held1_reg       <= '0;
            start_col_reg   <= '0;
            start_row_reg   <= '0;
            done_reg        <= 1'b1;
        end
        else
        begin
            hdr_pos_reg     <= hdr_pos_next;
            data_offset_reg <= data_offset_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            phase_reg       <= phase_next;
            held0_reg       <= held0_next;
            held1_reg       <= held1_next;
            start_col_reg   <= start_col_next;
            start_row_reg   <= start_row_next;
            done_reg        <= done_next;
        end
    end

endmodule

// File: hw/rtl/bsfb_queue.sv
// short pixel queue between parser and address unit
module bsfb_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bsfb_pkg::pixel_token_t push_token,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output bsfb_pkg::pixel_token_t head_token
);

    bsfb_pkg::pixel_token_t                entries_reg [bsfb_pkg::QUEUE_DEPTH];
    logic [bsfb_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [bsfb_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [bsfb_pkg::QUEUE_CNT_W-1:0]      count_reg, count_next;

    assign full       = (count_reg == bsfb_pkg::QUEUE_CNT_W'(bsfb_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_token = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + bsfb_pkg::QUEUE_CNT_W'(push)
                                - bsfb_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bsfb_pkg::QUEUE_CNT_W'(bsfb_pkg::QUEUE_DEPTH))
        else $error("pixel queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("pixel pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pixel popped from empty queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// File: hw/rtl/bsfb_back.sv
// config registers and two-stage framebuffer address unit
module bsfb_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsfb_pkg::cfg_write_t  cfg,
    input  logic                  head_valid,
    input  bsfb_pkg::pixel_token_t head_token,
    output logic                  pop,
    bsfb_pixel_if.source          pixel
);

    logic [31:0] frame_base_reg;
    logic [15:0] row_pitch_reg;

    logic        a_valid_reg;
    logic [31:0] a_product_reg;
    logic [31:0] a_colterm_reg;
    logic [7:0]  a_byte0_reg, a_byte1_reg, a_byte2_reg;
    logic        a_last_reg;

    logic        b_valid_reg;
    logic [31:0] b_address_reg;
    logic [7:0]  b_byte0_reg, b_byte1_reg, b_byte2_reg;
    logic        b_last_reg;

    logic        a_ready;
    logic        b_ready;
    logic [32:0] product;
    logic [31:0] colterm;

    assign b_ready = !b_valid_reg || pixel.ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = head_valid && a_ready;

    assign product = 33'(head_token.row) * 33'(row_pitch_reg);
    assign colterm = frame_base_reg + {13'd0, head_token.column, 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= bsfb_pkg::FRAME_BASE_RESET;
            row_pitch_reg  <= bsfb_pkg::ROW_PITCH_RESET;
        end
        else if (cfg.enable)
        begin
            case (cfg.index)
                bsfb_pkg::REG_FRAME_BASE: frame_base_reg <= cfg.data;
                bsfb_pkg::REG_ROW_PITCH:  row_pitch_reg  <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= head_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_product_reg <= product[31:0];
            a_colterm_reg <= colterm;
            a_byte0_reg   <= head_token.byte_zero;
            a_byte1_reg   <= head_token.byte_one;
            a_byte2_reg   <= head_token.byte_two;
            a_last_reg    <= head_token.last_pixel;
        end
        if (b_ready && a_valid_reg)
        begin
            b_address_reg <= a_product_reg + a_colterm_reg;
            b_byte0_reg   <= a_byte0_reg;
            b_byte1_reg   <= a_byte1_reg;
            b_byte2_reg   <= a_byte2_reg;
            b_last_reg    <= a_last_reg;
        end
    end

    assign pixel.valid         = b_valid_reg;
    assign pixel.write_address = b_address_reg;
    assign pixel.byte_zero     = b_byte0_reg;
    assign pixel.byte_one      = b_byte1_reg;
    assign pixel.byte_two      = b_byte2_reg;
    assign pixel.last_pixel    = b_last_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_ready) |=> a_valid_reg)
        else $error("address stage lost a pixel under stall");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> a_valid_reg)
        else $error("popped pixel did not reach address stage");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_ready) |=> b_valid_reg)
        else $error("address stage transfer not registered");

endmodule

// File: hw/rtl/bmp_stream_to_framebuffer_blit.sv
// top level of the bitmap stream to framebuffer blitter
//
// channel   dir  payload                                              handshake
// stream    in   data_byte, first_byte, origin_x, origin_y            valid/ready
// pixel     out  write_address, byte_zero/one/two, last_pixel         valid/ready
// config    in   register_index, write_data                           write_enable
//
// one file byte per cycle while the queue is not full; a pixel write follows its
// third byte into the parser, through the queue and the multiply and add stages
// the row-times-pitch multiplier is registered before the final add
// reset puts the parser in idle until a first byte; registers take their defaults
// a stalled pixel output fills the four-entry queue before stream ready drops
module bmp_stream_to_framebuffer_blit
(
    input  logic                              clk,
    input  logic                              rst_n,
    bsfb_byte_if.sink                         stream,
    bsfb_pixel_if.source                      pixel,
    input  logic                              write_enable,
    input  bsfb_pkg::reg_index_t              register_index,
    input  logic [bsfb_pkg::CFG_DATA_W-1:0]   write_data
);

    bsfb_pkg::cfg_write_t   cfg;
    bsfb_pkg::pixel_token_t push_token;
    bsfb_pkg::pixel_token_t head_token;
    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   head_valid;

    assign cfg.enable = write_enable;
    assign cfg.index  = register_index;
    assign cfg.data   = write_data;

    bsfb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .queue_full (queue_full),
        .push       (push),
        .token      (push_token)
    );

    bsfb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    bsfb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_token (head_token),
        .pop        (pop),
        .pixel      (pixel)
    );

endmodule
